/* rtl/wkp_pkg.sv */
// Shared types, codes and decode helpers of the Wiegand keypad PIN collector.
`default_nettype none

package wkp_pkg;

	// Function codes carried in the input tuser
	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_POLL = 2'd1,
		FUNC_SEND = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	// Configuration register indexes
	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_END_KEY = 2'd2;

	// Configuration reset values
	localparam logic        MODE_RESET    = 1'b0;
	localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
	localparam logic [3:0]  END_KEY_RESET = 4'd11;

	// Reader frame lengths per key
	localparam logic [7:0] BITS_4_MODE = 8'd4;
	localparam logic [7:0] BITS_8_MODE = 8'd8;

	// Codes 12 and above fold onto key '1'
	localparam logic [3:0] KEY_FOLD_MIN = 4'd12;
	localparam logic [3:0] KEY_ONE      = 4'd1;

	localparam logic [15:0] IDLE_MAX = 16'hFFFF;

	// Sequencer states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SEND = 1'b1
	} state_t;

	// Per-cell control
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

	// Decode the top nibble of a reader byte into a key code, inverted in 8-bit mode
	function automatic logic [3:0] decode_key(input logic [7:0] raw, input logic eight);
		logic [3:0] n;
		begin
			n = raw[7:4];
			if (eight) begin
				n = ~n;
			end
			if (n >= KEY_FOLD_MIN) begin
				n = KEY_ONE;
			end
			return n;
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/wiegand_keypad_pin_collector.sv */
// Top level of the Wiegand keypad PIN collector: control, key chain, output register.
// Tick and poll words are taken while the output register is free; their result word shows the cycle after accept.
// A send of n stored keys enters the send state, then shifts one key per cycle out of the
// head of the key cell chain while the output register is free; an empty send gives one word.
// Output words stall the chain through the single output register.
// Reset (arst_n low, asynchronous) clears the count, flags, idle timer, sequencer and
// output valid, and loads the configuration defaults; key cells are not reset.
`default_nettype none

module wiegand_keypad_pin_collector
	import wkp_pkg::*;
#(
	parameter int MAX_PIN_KEYS = 16,
	localparam int LEN_W = $clog2(MAX_PIN_KEYS + 1),
	localparam int OUT_W = 9 + LEN_W,
	localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8
)
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration write port
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_wdata,
	// input stream
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [15:0]         s_tdata,  // bit_count[7:0], raw_byte[15:8]
	input  wire logic [1:0]          s_tuser,  // func[1:0]
	// output stream
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [OUT_TD_W-1:0]      m_tdata,  // key_code, key_valid, pin_ready,
	                                           // pin_length, frame_error,
	                                           // reader_clear, overflow, zero pad
	output logic                     m_tlast
);

	// Configuration
	logic        mode_q;
	logic [15:0] timeout_q;
	logic [3:0]  end_key_q;

	// Entry state
	logic [LEN_W-1:0] count_q, count_d;
	logic             ready_q, ready_d;
	logic [15:0]      idle_q, idle_d;
	logic [LEN_W-1:0] left_q, left_d;
	state_t           state_q, state_d;

	// Output register
	logic             m_tvalid_q;
	logic [3:0]       o_key_q, o_key_d;
	logic             o_valid_q, o_valid_d;
	logic             o_last_q, o_last_d;
	logic             o_ready_q, o_ready_d;
	logic [LEN_W-1:0] o_len_q, o_len_d;
	logic             o_ferr_q, o_ferr_d;
	logic             o_clr_q, o_clr_d;
	logic             o_ovf_q, o_ovf_d;
	logic             o_load;

	// Handshake and decode
	logic       out_free;
	logic       acc;
	logic       emit;
	logic       append;
	logic       shift;
	func_t      func;
	logic [7:0] bit_count;
	logic [7:0] raw_byte;
	logic [3:0] new_key;
	logic [7:0] want;

	// Key chain
	logic [3:0]  cell_key  [MAX_PIN_KEYS];
	logic [3:0]  cell_next [MAX_PIN_KEYS];
	cell_ctrl_t  cell_ctrl [MAX_PIN_KEYS];

	assign func      = func_t'(s_tuser);
	assign bit_count = s_tdata[7:0];
	assign raw_byte  = s_tdata[15:8];
	assign new_key   = decode_key(raw_byte, mode_q);
	assign want      = mode_q ? BITS_8_MODE : BITS_4_MODE;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign acc      = s_tvalid && s_tready;
	assign emit     = (state_q == ST_SEND) && out_free;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_RESET;
			timeout_q <= TIMEOUT_RESET;
			end_key_q <= END_KEY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:    mode_q    <= cfg_wdata[0];
				REG_TIMEOUT: timeout_q <= cfg_wdata;
				REG_END_KEY: end_key_q <= cfg_wdata[3:0];
				default:     ;
			endcase
		end
	end

	// Next state of the send sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && func == FUNC_SEND && count_q != '0) begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: begin
				if (emit && left_q == LEN_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Entry update and result word
	always_comb begin
		count_d   = count_q;
		ready_d   = ready_q;
		idle_d    = idle_q;
		left_d    = left_q;
		append    = 1'b0;
		shift     = 1'b0;
		o_load    = 1'b0;
		o_key_d   = '0;
		o_valid_d = 1'b0;
		o_last_d  = 1'b1;
		o_ferr_d  = 1'b0;
		o_clr_d   = 1'b0;
		o_ovf_d   = 1'b0;
		if (acc) begin
			o_load = 1'b1;
			case (func)
				FUNC_TICK: begin
					if (idle_q != IDLE_MAX) begin
						idle_d = idle_q + 16'd1;
					end
				end
				FUNC_POLL: begin
					if (bit_count == 8'd0) begin
						if (idle_q > timeout_q) begin
							ready_d = (count_q != '0);
						end
					end else if (bit_count != want) begin
						count_d  = '0;
						ready_d  = 1'b0;
						idle_d   = '0;
						o_ferr_d = 1'b1;
						o_clr_d  = 1'b1;
					end else begin
						idle_d  = '0;
						o_clr_d = 1'b1;
						if (new_key == end_key_q) begin
							ready_d = (count_q != '0);
						end else if (count_q < LEN_W'(MAX_PIN_KEYS)) begin
							append  = 1'b1;
							count_d = count_q + LEN_W'(1);
						end else begin
							o_ovf_d = 1'b1;
						end
					end
				end
				FUNC_SEND: begin
					if (count_q == '0) begin
						ready_d = 1'b0;
						idle_d  = '0;
						o_clr_d = 1'b1;
					end else begin
						o_load = 1'b0;
						left_d = count_q;
					end
				end
				default: ;
			endcase
		end else if (emit) begin
			// Drain the head cell and advance the chain
			o_load    = 1'b1;
			shift     = 1'b1;
			o_key_d   = cell_key[0];
			o_valid_d = 1'b1;
			o_last_d  = (left_q == LEN_W'(1));
			left_d    = left_q - LEN_W'(1);
			if (o_last_d) begin
				count_d = '0;
				ready_d = 1'b0;
				idle_d  = '0;
				o_clr_d = 1'b1;
			end
		end
		o_ready_d = ready_d;
		o_len_d   = count_d;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			ready_q    <= 1'b0;
			idle_q     <= '0;
			left_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ready_q <= ready_d;
			idle_q  <= idle_d;
			left_q  <= left_d;
			if (o_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (o_load) begin
			o_key_q   <= o_key_d;
			o_valid_q <= o_valid_d;
			o_last_q  <= o_last_d;
			o_ready_q <= o_ready_d;
			o_len_q   <= o_len_d;
			o_ferr_q  <= o_ferr_d;
			o_clr_q   <= o_clr_d;
			o_ovf_q   <= o_ovf_d;
		end
	end

	// Row of key cells, head at index zero
	for (genvar i = 0; i < MAX_PIN_KEYS; i++) begin : g_cell
		if (i == MAX_PIN_KEYS - 1) begin : g_tail
			assign cell_next[i] = '0;
		end else begin : g_mid
			assign cell_next[i] = cell_key[i+1];
		end
		assign cell_ctrl[i].load  = append && (count_q == LEN_W'(i));
		assign cell_ctrl[i].shift = shift;

		wkp_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl[i]),
			.key_in   (new_key),
			.next_key (cell_next[i]),
			.key      (cell_key[i])
		);
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = OUT_TD_W'({o_ovf_q, o_clr_q, o_ferr_q, o_len_q,
		o_ready_q, o_valid_q, o_key_q});

`ifndef SYNTHESIS
	a_no_accept_in_send: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEND) |-> !s_tready)
		else $error("input accepted while sending keys");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LEN_W'(MAX_PIN_KEYS))
		else $error("key count beyond capacity");

	a_send_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEND) |-> (left_q != '0 && left_q <= count_q))
		else $error("send counter out of range");

	a_send_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && left_q == LEN_W'(1)) |=> (count_q == '0 && !ready_q && state_q == ST_IDLE))
		else $error("final send word did not clear entry");
`endif

endmodule

`default_nettype wire

/* rtl/wkp_cell.sv */
// One key slot of the PIN chain: loads a new key or takes its neighbor's key.
`default_nettype none

module wkp_cell
	import wkp_pkg::*;
(
	input  wire logic       clk,
	input  wire cell_ctrl_t ctrl,
	input  wire logic [3:0] key_in,
	input  wire logic [3:0] next_key,
	output logic      [3:0] key
);

	logic [3:0] key_q;

	// Load on append, advance toward the head on send, else hold
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q <= key_in;
		end else if (ctrl.shift) begin
			key_q <= next_key;
		end
	end

	assign key = key_q;

endmodule

`default_nettype wire
